// ===== src/espp_pkg.sv =====
package espp_pkg;

  // Parse phases of the front end.
  typedef enum logic [2:0] {
    PhReport = 3'd0,
    PhPage   = 3'd1,
    PhDesc   = 3'd2,
    PhSkip   = 3'd3,
    PhDone   = 3'd4
  } phase_e;

  // Configuration register indexes.
  localparam logic [7:0] CfgResponseLimit = 8'd0;
  localparam logic [7:0] CfgStatusLimit   = 8'd1;

  // Register reset values.
  localparam logic [15:0] ResponseLimitRst = 16'd4096;
  localparam logic [15:0] StatusLimitRst   = 16'd65535;

  // Leading descriptor bytes that must be zero for a storage slot to be padding.
  localparam logic [15:0] ZeroCheckBytes = 16'd12;

  // Header and descriptor geometry.
  localparam int unsigned HdrBytes  = 8;
  localparam int unsigned DescBytes = 12;

  // Element type code of a storage page.
  localparam logic [3:0] StorageKind = 4'h2;

  // Bits of descriptor byte 2 and byte 9.
  localparam logic [7:0] FullMask   = 8'h01;
  localparam logic [7:0] ExceptMask = 8'h04;
  localparam logic [7:0] SvalidMask = 8'h80;

  // Result of one parsed byte: an element record, an end record, or both.
  typedef struct packed {
    logic        elem_v;
    logic        end_v;
    logic [15:0] element_address;
    logic [3:0]  element_kind;
    logic        medium_present;
    logic        exception_flag;
    logic        source_known;
    logic [15:0] source_address;
    logic [15:0] record_count;
  } rec_t;

endpackage

// ===== src/espp_front.sv =====
module espp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          data_i,
  input  logic                last_i,
  input  logic                ready_i,
  input  logic [15:0]         response_limit_i,
  input  logic [15:0]         status_limit_i,
  output logic                push_o,
  output espp_pkg::rec_t      rec_o
);
  import espp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [16:0] bp_q, bp_d;
  logic [16:0] rend_q, rend_d;
  logic [16:0] pend_q, pend_d;
  logic [15:0] dl_q, dl_d;
  logic [3:0]  kind_q, kind_d;
  logic        nz_q, nz_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  hdr_q [HdrBytes];
  logic [7:0]  hdr_d [HdrBytes];
  logic [7:0]  desc_q [DescBytes];
  logic [7:0]  desc_d [DescBytes];
  logic [7:0]  view [DescBytes];
  logic        acc;

  assign acc = valid_i & ready_i;

  // Descriptor bytes as they stand once the current byte is taken in.
  always_comb begin
    for (int k = 0; k < DescBytes; k++) begin
      view[k] = (idx_q == 16'(k)) ? data_i : desc_q[k];
    end
  end

  // Parse step for one byte.
  always_comb begin
    logic        fin;
    logic        emit;
    logic        do_inner;
    logic        do_skip;
    logic        do_outer;
    logic [23:0] rb;
    logic [24:0] ext;
    logic [7:0]  flags;
    phase_d  = phase_q;
    bp_d     = bp_q;
    rend_d   = rend_q;
    pend_d   = pend_q;
    dl_d     = dl_q;
    kind_d   = kind_q;
    nz_d     = nz_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    hdr_d    = hdr_q;
    desc_d   = desc_q;
    fin      = 1'b0;
    emit     = 1'b0;
    do_inner = 1'b0;
    do_skip  = 1'b0;
    do_outer = 1'b0;
    rb       = '0;
    ext      = '0;
    flags    = '0;

    unique case (phase_q)
      PhReport: begin
        hdr_d[idx_q[2:0]] = data_i;
        idx_d = idx_q + 16'd1;
        bp_d  = bp_q + 17'd1;
        if (idx_q[2:0] == 3'd7) begin
          rb = {hdr_q[5], hdr_q[6], data_i};
          if (rb == '0) begin
            fin = 1'b1;
          end else begin
            ext = {1'b0, rb} + 25'd8;
            rend_d = (ext > {9'd0, response_limit_i}) ? {1'b0, response_limit_i} : ext[16:0];
            do_outer = 1'b1;
          end
        end
      end
      PhPage: begin
        hdr_d[idx_q[2:0]] = data_i;
        idx_d = idx_q + 16'd1;
        bp_d  = bp_q + 17'd1;
        if (idx_q[2:0] == 3'd7) begin
          rb = {hdr_q[5], hdr_q[6], data_i};
          if ({hdr_q[2], hdr_q[3]} == 16'd0 || rb == '0) begin
            fin = 1'b1;
          end else begin
            ext    = {8'd0, bp_d} + {1'b0, rb};
            pend_d = (ext > {8'd0, rend_q}) ? rend_q : ext[16:0];
            kind_d = hdr_q[0][3:0];
            dl_d   = {hdr_q[2], hdr_q[3]};
            do_inner = 1'b1;
          end
        end
      end
      PhDesc: begin
        if (idx_q < 16'(DescBytes)) begin
          desc_d[idx_q[3:0]] = data_i;
        end
        if (idx_q < ZeroCheckBytes && data_i != 8'd0) begin
          nz_d = 1'b1;
        end
        idx_d = idx_q + 16'd1;
        bp_d  = bp_q + 17'd1;
        if ({1'b0, idx_q} + 17'd1 >= {1'b0, dl_q}) begin
          if (nz_d || kind_q != StorageKind) begin
            emit  = 1'b1;
            cnt_d = cnt_q + 16'd1;
          end
          do_inner = 1'b1;
        end
      end
      PhSkip: begin
        bp_d = bp_q + 17'd1;
        if (bp_d >= pend_d) begin
          do_outer = 1'b1;
        end
      end
      PhDone: begin
        // Bytes after the end record are dropped until the final byte.
      end
      default: begin
        phase_d = PhDone;
      end
    endcase

    // Next descriptor, or leave the page.
    if (do_inner) begin
      if (cnt_d >= status_limit_i) begin
        fin = 1'b1;
      end else if ({1'b0, bp_d} + {2'b0, dl_d} <= {1'b0, pend_d}) begin
        if (dl_d < 16'd2) begin
          do_skip = 1'b1;
        end else begin
          phase_d = PhDesc;
          idx_d   = '0;
          nz_d    = 1'b0;
        end
      end else begin
        do_skip = 1'b1;
      end
    end

    // Skip what is left of the page.
    if (do_skip) begin
      if (bp_d >= pend_d) begin
        do_outer = 1'b1;
      end else begin
        phase_d = PhSkip;
      end
    end

    // Another page header, or the end of the report.
    if (do_outer) begin
      if ({1'b0, bp_d} + 18'd8 <= {1'b0, rend_d} && cnt_d < status_limit_i) begin
        phase_d = PhPage;
        idx_d   = '0;
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      phase_d = PhDone;
    end

    // The final byte closes any open parse and rearms for a new report.
    if (last_i) begin
      if (phase_d != PhDone) begin
        fin = 1'b1;
      end
      phase_d = PhReport;
      bp_d    = '0;
      rend_d  = '0;
      pend_d  = '0;
      dl_d    = '0;
      kind_d  = '0;
      nz_d    = 1'b0;
      idx_d   = '0;
    end

    // Record built from this byte.
    flags = (dl_q >= 16'd3) ? view[2] : 8'd0;
    rec_o.elem_v          = emit;
    rec_o.end_v           = fin;
    rec_o.element_address = {view[0], view[1]};
    rec_o.element_kind    = kind_q;
    rec_o.medium_present  = (flags & FullMask) != 8'd0;
    rec_o.exception_flag  = (flags & ExceptMask) != 8'd0;
    rec_o.source_known    = (dl_q >= 16'd12) && ((view[9] & SvalidMask) != 8'd0);
    rec_o.source_address  = (dl_q >= 16'd12) ? {view[10], view[11]} : 16'd0;
    rec_o.record_count    = cnt_d;
    push_o = acc & (emit | fin);

    if (last_i) begin
      cnt_d = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhReport;
      bp_q    <= '0;
      rend_q  <= '0;
      pend_q  <= '0;
      dl_q    <= '0;
      kind_q  <= '0;
      nz_q    <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      bp_q    <= bp_d;
      rend_q  <= rend_d;
      pend_q  <= pend_d;
      dl_q    <= dl_d;
      kind_q  <= kind_d;
      nz_q    <= nz_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // Header and descriptor byte stores.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      hdr_q  <= hdr_d;
      desc_q <= desc_d;
    end
  end

endmodule

// ===== src/espp_queue.sv =====
module espp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  espp_pkg::rec_t wdata_i,
  output logic           ready_o,
  output logic           valid_o,
  output espp_pkg::rec_t rdata_o,
  input  logic           pop_i
);
  import espp_pkg::*;

  localparam int unsigned Depth = 4;

  rec_t        mem_q [Depth];
  logic [1:0]  wptr_q, wptr_d;
  logic [1:0]  rptr_q, rptr_d;
  logic [2:0]  fill_q, fill_d;
  logic        do_push;
  logic        do_pop;

  assign ready_o = fill_q != 3'(Depth);
  assign valid_o = fill_q != 3'd0;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill updates.
  always_comb begin
    wptr_d = do_push ? wptr_q + 2'd1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 2'd1 : rptr_q;
    fill_d = fill_q + 3'(do_push) - 3'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/espp_back.sv =====
module espp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  espp_pkg::rec_t rec_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic           m_kind_o,
  // element_address, element_kind, medium_present, exception_flag,
  // source_known, source_address, record_count, one zero pad bit
  output logic [55:0]    m_data_o
);
  import espp_pkg::*;

  logic        vld_q, vld_d;
  logic        half_q, half_d;
  logic        kind_q, kind_d;
  logic [55:0] data_q, data_d;
  logic        load;

  assign load = !vld_q || m_ready_i;

  // Split a queue entry into its element record and its end record.
  always_comb begin
    vld_d  = vld_q;
    half_d = half_q;
    kind_d = kind_q;
    data_d = data_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = valid_i;
      if (valid_i) begin
        if (rec_i.elem_v && !half_q) begin
          kind_d = 1'b0;
          data_d = {1'b0, rec_i.record_count, rec_i.source_address, rec_i.source_known,
                    rec_i.exception_flag, rec_i.medium_present, rec_i.element_kind,
                    rec_i.element_address};
          if (rec_i.end_v) begin
            half_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          kind_d = 1'b1;
          data_d = {1'b0, rec_i.record_count, 39'd0};
          half_d = 1'b0;
          pop_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      half_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      half_q <= half_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
  end

  assign m_valid_o = vld_q;
  assign m_kind_o  = kind_q;
  assign m_data_o  = data_q;

endmodule

// ===== src/element_status_page_parser_unit.sv =====
// Element status report parser.
// The slave stream carries one response byte per request in s_axis_tdata,
// with s_axis_tlast on the last byte of the response. The master stream
// carries one record per request: m_axis_tuser is 0 for an element record
// and 1 for the end record that closes each report with the record count.
// The configuration channel writes the buffer length (index 0) and the
// record limit (index 1); write it only while the block is idle.
// Throughput is one byte per cycle while the queue has room. The front
// end parses a byte in the cycle it is taken; its record then passes
// through the queue and the output register. One byte can close a
// descriptor and the report at once; its two records leave in turn.
// A four-entry queue separates parsing from output. When the receiver
// stalls, records pile up there and s_axis_tready drops once it is full.
// Reset empties the queue and the output register, rearms the parser for
// a new report and loads the register defaults (4096 and 65535). After
// the last byte the parser rearms the same way and keeps the registers.
module element_status_page_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // element_address, element_kind, medium_present, exception_flag,
  // source_known, source_address, record_count, one zero pad bit
  output logic [55:0] m_axis_tdata,
  // record_kind
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import espp_pkg::*;

  logic [15:0] response_limit_q;
  logic [15:0] status_limit_q;
  logic        q_ready;
  logic        q_valid;
  logic        push;
  logic        pop;
  rec_t        wrec;
  rec_t        rrec;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = q_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      response_limit_q <= ResponseLimitRst;
      status_limit_q   <= StatusLimitRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgResponseLimit) begin
        response_limit_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgStatusLimit) begin
        status_limit_q <= cfg_data_i;
      end
    end
  end

  espp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (s_axis_tvalid),
    .data_i           (s_axis_tdata),
    .last_i           (s_axis_tlast),
    .ready_i          (q_ready),
    .response_limit_i (response_limit_q),
    .status_limit_i   (status_limit_q),
    .push_o           (push),
    .rec_o            (wrec)
  );

  espp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wrec),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .rdata_o (rrec),
    .pop_i   (pop)
  );

  espp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .rec_i     (rrec),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_kind_o  (m_axis_tuser),
    .m_data_o  (m_axis_tdata)
  );

endmodule

// ===== dv/element_status_page_parser_unit_tb.sv =====
module element_status_page_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import espp_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned DrainCycles  = 6;
  localparam int unsigned TailCycles   = 8;
  localparam int unsigned StallCycles  = 300;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RandomBytes  = 300;
  localparam int unsigned DefaultIdle  = 34;

  // One record as it leaves the block, fields unpacked.
  typedef struct packed {
    logic        kind;
    logic [15:0] addr;
    logic [3:0]  elem_kind;
    logic        full;
    logic        except;
    logic        src_known;
    logic [15:0] src_addr;
    logic [15:0] count;
  } record_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = CfgResponseLimit;
  logic [15:0] cfg_data_i    = 16'h0000;

  element_status_page_parser_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shared run state.
  int unsigned idle_pct = DefaultIdle;
  int unsigned stall_seq = 0;
  int unsigned stall_done = 0;
  int unsigned hold_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  record_t     pending_records[$];
  record_t     seen_rec;
  record_t     want_rec;
  logic [7:0]  report_q[$];

  // Parser shadow state.
  phase_e      parse_ph;
  logic [16:0] byte_pos;
  logic [16:0] report_end;
  logic [16:0] page_stop;
  logic [15:0] desc_size;
  logic [3:0]  page_kind;
  logic [7:0]  hdr_q [HdrBytes];
  logic [7:0]  desc_q [DescBytes];
  logic        nonzero_seen;
  logic [15:0] elem_count;
  int unsigned field_idx;
  logic [15:0] resp_limit;
  logic [15:0] stat_limit;

  // Puts the parser back at the start of a report; registers are kept.
  function automatic void rearm_parser();
    parse_ph     = PhReport;
    byte_pos     = '0;
    report_end   = '0;
    page_stop    = '0;
    desc_size    = '0;
    page_kind    = '0;
    nonzero_seen = 1'b0;
    elem_count   = '0;
    field_idx    = 0;
    foreach (hdr_q[i]) hdr_q[i] = '0;
    foreach (desc_q[i]) desc_q[i] = '0;
  endfunction

  // The end record carries the number of element records so far.
  function automatic void close_report();
    record_t rec;
    rec = '0;
    rec.kind  = 1'b1;
    rec.count = elem_count;
    pending_records.push_back(rec);
    parse_ph = PhDone;
  endfunction

  // Another page header needs eight bytes of room and the record limit not yet hit.
  function automatic void next_page_or_close();
    if (32'(byte_pos) + 32'd8 <= 32'(report_end) && elem_count < stat_limit) begin
      parse_ph  = PhPage;
      field_idx = 0;
    end else begin
      close_report();
    end
  endfunction

  function automatic void skip_rest_of_page();
    if (byte_pos >= page_stop) begin
      next_page_or_close();
    end else begin
      parse_ph = PhSkip;
    end
  endfunction

  // Decides what follows a page header or a finished descriptor.
  function automatic void next_descriptor();
    if (elem_count >= stat_limit) begin
      close_report();
    end else if (32'(byte_pos) + 32'(desc_size) <= 32'(page_stop)) begin
      if (desc_size < 16'd2) begin
        skip_rest_of_page();
      end else begin
        parse_ph     = PhDesc;
        field_idx    = 0;
        nonzero_seen = 1'b0;
      end
    end else begin
      skip_rest_of_page();
    end
  endfunction

  // Short descriptors read their flags and source fields as zero.
  function automatic void push_element();
    record_t    rec;
    logic [7:0] flags;
    rec   = '0;
    flags = (desc_size >= 16'd3) ? desc_q[2] : 8'h00;
    elem_count = elem_count + 16'd1;
    rec.addr      = {desc_q[0], desc_q[1]};
    rec.elem_kind = page_kind;
    rec.full      = |(flags & FullMask);
    rec.except    = |(flags & ExceptMask);
    if (desc_size >= 16'(DescBytes)) begin
      rec.src_known = |(desc_q[9] & SvalidMask);
      rec.src_addr  = {desc_q[10], desc_q[11]};
    end
    rec.count = elem_count;
    pending_records.push_back(rec);
  endfunction

  // Advances the shadow parser by one accepted byte.
  function automatic void absorb_byte(input logic [7:0] value, input logic is_final);
    logic [23:0] count24;
    logic [15:0] dlen;
    logic [31:0] span;
    case (parse_ph)
      PhReport: begin
        hdr_q[field_idx] = value;
        field_idx++;
        byte_pos++;
        if (field_idx >= HdrBytes) begin
          count24 = {hdr_q[5], hdr_q[6], hdr_q[7]};
          if (count24 == '0) begin
            close_report();
          end else begin
            span = 32'd8 + 32'(count24);
            if (span > 32'(resp_limit)) span = 32'(resp_limit);
            report_end = span[16:0];
            next_page_or_close();
          end
        end
      end
      PhPage: begin
        hdr_q[field_idx] = value;
        field_idx++;
        byte_pos++;
        if (field_idx >= HdrBytes) begin
          dlen    = {hdr_q[2], hdr_q[3]};
          count24 = {hdr_q[5], hdr_q[6], hdr_q[7]};
          if (dlen == '0 || count24 == '0) begin
            close_report();
          end else begin
            span = 32'(byte_pos) + 32'(count24);
            if (span > 32'(report_end)) span = 32'(report_end);
            page_stop = span[16:0];
            page_kind = hdr_q[0][3:0];
            desc_size = dlen;
            next_descriptor();
          end
        end
      end
      PhDesc: begin
        if (field_idx < DescBytes) desc_q[field_idx] = value;
        if (field_idx < 32'(ZeroCheckBytes) && value != 8'h00) nonzero_seen = 1'b1;
        field_idx++;
        byte_pos++;
        if (field_idx >= 32'(desc_size)) begin
          // Storage slots whose leading ZeroCheckBytes bytes are all zero are padding and produce no record.
          if (nonzero_seen || page_kind != StorageKind) push_element();
          next_descriptor();
        end
      end
      PhSkip: begin
        byte_pos++;
        if (byte_pos >= page_stop) next_page_or_close();
      end
      default: begin
      end
    endcase
    if (is_final) begin
      if (parse_ph != PhDone) close_report();
      rearm_parser();
    end
  endfunction

  function automatic string describe(input record_t r);
    return $sformatf({"kind=%0d addr=%h elem_kind=%h full=%0d except=%0d",
                      " src_known=%0d src=%h count=%0d"},
                     r.kind, r.addr, r.elem_kind, r.full, r.except, r.src_known, r.src_addr,
                     r.count);
  endfunction

  function automatic bit same_record(input record_t a, input record_t b);
    return a.kind === b.kind && a.addr === b.addr && a.elem_kind === b.elem_kind &&
           a.full === b.full && a.except === b.except && a.src_known === b.src_known &&
           a.src_addr === b.src_addr && a.count === b.count;
  endfunction

  // Receiver: random stalls, plus one long hold-off when a test asks for it.
  always @(negedge clk_i) begin
    if (stall_seq != stall_done) begin
      stall_done = stall_seq;
      hold_left  = StallCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Compares each record request with the oldest expected record.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_rec.kind      = m_axis_tuser;
      seen_rec.addr      = m_axis_tdata[15:0];
      seen_rec.elem_kind = m_axis_tdata[19:16];
      seen_rec.full      = m_axis_tdata[20];
      seen_rec.except    = m_axis_tdata[21];
      seen_rec.src_known = m_axis_tdata[22];
      seen_rec.src_addr  = m_axis_tdata[38:23];
      seen_rec.count     = m_axis_tdata[54:39];
      if (pending_records.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("[%0t] unexpected record: %s", $time, describe(seen_rec));
        end
      end else begin
        want_rec = pending_records.pop_front();
        if (!same_record(want_rec, seen_rec)) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("[%0t] record mismatch", $time);
            $display("  expected %s", describe(want_rec));
            $display("  actual   %s", describe(seen_rec));
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[%0t] timeout after %0d cycles", $time, cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one byte request and waits for it to be taken.
  task automatic send_byte(input logic [7:0] value, input logic is_final);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= is_final;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_byte(value, is_final);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_report();
    foreach (report_q[i]) send_byte(report_q[i], i == report_q.size() - 1);
  endtask

  // Lets every expected record drain and the pipeline settle.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [7:0] index, input logic [15:0] value);
    wait_for_drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CfgResponseLimit) begin
      resp_limit = value;
    end else if (index == CfgStatusLimit) begin
      stat_limit = value;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void start_report();
    report_q.delete();
    repeat (HdrBytes) report_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void set_report_length(input logic [23:0] count);
    report_q[5] = count[23:16];
    report_q[6] = count[15:8];
    report_q[7] = count[7:0];
  endfunction

  // Appends a page header and its descriptors; returns the page byte count.
  function automatic int unsigned add_page(input logic [3:0] kind, input logic [15:0] dlen,
                                           input int unsigned ndesc, input int unsigned pad_pct,
                                           input int unsigned slack);
    int unsigned n;
    int unsigned pbytes;
    bit          blank;
    logic [7:0]  rnd;
    n = (dlen > 16'd40) ? 0 : ndesc;
    pbytes = 32'(dlen) * n + slack;
    rnd = 8'($urandom_range(255));
    report_q.push_back({rnd[7:4], kind});
    report_q.push_back(8'($urandom_range(255)));
    report_q.push_back(dlen[15:8]);
    report_q.push_back(dlen[7:0]);
    report_q.push_back(8'($urandom_range(255)));
    report_q.push_back(8'(pbytes >> 16));
    report_q.push_back(8'(pbytes >> 8));
    report_q.push_back(8'(pbytes));
    repeat (n) begin
      blank = ($urandom_range(99) < pad_pct);
      for (int j = 0; j < int'(dlen); j++) begin
        report_q.push_back((blank && j < int'(ZeroCheckBytes)) ?
                           8'h00 : 8'($urandom_range(255)));
      end
    end
    repeat (slack) report_q.push_back(8'($urandom_range(255)));
    return pbytes;
  endfunction

  function automatic logic [15:0] pick_desc_len();
    case ($urandom_range(15))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd3;
      4: return 16'd11;
      5: return 16'd12;
      6: return 16'd13;
      7: return 16'd16;
      8: return 16'($urandom_range(17, 40));
      9: return 16'($urandom_range(41, 65535));
      default: return 16'($urandom_range(4, 10));
    endcase
  endfunction

  // Builds a mostly well-formed report; some are misstated, cut or padded at the tail.
  function automatic void make_report(input int unsigned max_pages, input int unsigned max_descs);
    int unsigned body;
    int unsigned cut;
    logic [3:0]  kind;
    start_report();
    body = 0;
    repeat ($urandom_range(1, max_pages)) begin
      kind = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4));
      body += add_page(kind, pick_desc_len(), $urandom_range(1, max_descs),
                       ($urandom_range(1) == 0) ? 0 : 33,
                       ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0);
    end
    case ($urandom_range(9))
      0: set_report_length(24'($urandom));
      1: set_report_length(24'($urandom_range(body)));
      2: set_report_length(24'(body + $urandom_range(1, 20)));
      default: set_report_length(24'(body));
    endcase
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 4)) report_q.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(7) == 0) begin
      cut = $urandom_range(1, report_q.size());
      while (report_q.size() > cut) void'(report_q.pop_back());
    end
  endfunction

  function automatic void make_noise();
    report_q.delete();
    repeat ($urandom_range(1, 40)) report_q.push_back(8'($urandom_range(255)));
  endfunction

  // Byte extremes, a zero report length, a final byte inside the header and a
  // minimal two-byte descriptor.
  task automatic test_directed_edges();
    report_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_report();
    report_q = '{8'h00, 8'hFF, 8'h80};
    send_report();
    report_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0A,
                 8'hF3, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h02,
                 8'hFF, 8'hFF};
    send_report();
  endtask

  // Padding slots, short and oversized descriptors, and the ways a report ends early.
  task automatic test_special_pages();
    int unsigned body;
    start_report();
    body = add_page(StorageKind, 16'd13, 2, 100, 0);
    body += add_page(StorageKind, 16'd12, 2, 0, 0);
    body += add_page(4'h1, 16'd12, 1, 100, 0);
    body += add_page(4'h3, 16'd1, 0, 0, 3);
    body += add_page(4'h4, 16'd3, 1, 0, 2);
    body += add_page(StorageKind, 16'd0, 0, 0, 2);
    set_report_length(24'(body));
    send_report();
    // Leftover bytes too few for another page header.
    start_report();
    body = add_page(4'h1, 16'd2, 2, 0, 0);
    repeat (5) report_q.push_back(8'($urandom_range(255)));
    set_report_length(24'(body + 5));
    send_report();
    // An empty page ends the report.
    start_report();
    body = add_page(4'h2, 16'd4, 2, 0, 0);
    body += add_page(4'h1, 16'd4, 0, 0, 0);
    set_report_length(24'(body + 4));
    repeat (4) report_q.push_back(8'($urandom_range(255)));
    send_report();
  endtask

  task automatic test_status_limits();
    int unsigned body;
    write_register(CfgStatusLimit, 16'd0);
    make_report(2, 3);
    send_report();
    // The record that reaches the limit and the end record share one byte.
    write_register(CfgStatusLimit, 16'd1);
    start_report();
    body = add_page(4'h1, 16'd4, 3, 0, 0);
    set_report_length(24'(body));
    send_report();
    write_register(CfgStatusLimit, 16'd3);
    make_report(3, 4);
    send_report();
    write_register(CfgStatusLimit, 16'hFFFF);
  endtask

  task automatic test_buffer_limits();
    write_register(CfgResponseLimit, 16'd8);
    make_report(2, 3);
    send_report();
    write_register(CfgResponseLimit, 16'd40);
    repeat (3) begin
      make_report(3, 4);
      send_report();
    end
    write_register(CfgResponseLimit, 16'hFFFF);
    make_report(2, 3);
    send_report();
    write_register(CfgResponseLimit, ResponseLimitRst);
  endtask

  // Neither side idles here.
  task automatic test_back_to_back();
    idle_pct = 0;
    repeat (4) begin
      make_report(3, 4);
      send_report();
    end
    idle_pct = DefaultIdle;
  endtask

  // A long receiver hold-off while many short records are offered fills the
  // output queue and must stall the byte stream.
  task automatic test_backpressure();
    int unsigned body;
    start_report();
    body = add_page(4'h1, 16'd2, 24, 0, 0);
    set_report_length(24'(body));
    idle_pct = 0;
    stall_seq++;
    send_report();
    idle_pct = DefaultIdle;
  endtask

  task automatic test_random_reports();
    int unsigned start_bytes;
    int unsigned round;
    logic [15:0] limit;
    start_bytes = bytes_sent;
    round = 0;
    while (bytes_sent - start_bytes < RandomBytes) begin
      if (round % 5 == 4) begin
        case ($urandom_range(7))
          0: limit = 16'd8;
          1: limit = 16'hFFFF;
          2, 3: limit = 16'($urandom_range(8, 160));
          default: limit = ResponseLimitRst;
        endcase
        write_register(CfgResponseLimit, limit);
        case ($urandom_range(7))
          0: limit = 16'd0;
          1, 2: limit = 16'($urandom_range(1, 6));
          default: limit = StatusLimitRst;
        endcase
        write_register(CfgStatusLimit, limit);
      end
      if ($urandom_range(99) < 15) begin
        make_noise();
      end else begin
        make_report(3, 4);
      end
      send_report();
      round++;
    end
  endtask

  initial begin
    resp_limit = ResponseLimitRst;
    stat_limit = StatusLimitRst;
    rearm_parser();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_edges();
    test_special_pages();
    test_status_limits();
    test_buffer_limits();
    test_back_to_back();
    test_backpressure();
    test_random_reports();

    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && pending_records.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
